// ===== sv/rmq_pkg.sv =====
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int DataWidth = 16;
	localparam int FracBits  = 14;
	localparam int RadWidth  = 17;   // clamped radicand, unsigned
	localparam int DiffWidth = 17;   // off-diagonal sum or difference, signed
	localparam int SqWidth   = 16;   // floor(sqrt(rad << FracBits))
	localparam int SqSteps   = 16;   // one root bit per stage
	localparam int NumWidth  = 32;   // (|d| << FracBits) + S/2
	localparam int QuoBits   = 23;   // quotient bits that can be nonzero
	localparam int QueueDepth = 4;

	localparam logic signed [18:0] One = 19'sd16384;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} rmq_branch_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] m00;
		logic signed [DataWidth-1:0] m01;
		logic signed [DataWidth-1:0] m02;
		logic signed [DataWidth-1:0] m10;
		logic signed [DataWidth-1:0] m11;
		logic signed [DataWidth-1:0] m12;
		logic signed [DataWidth-1:0] m20;
		logic signed [DataWidth-1:0] m21;
		logic signed [DataWidth-1:0] m22;
	} rmq_in_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] qw;
		logic signed [DataWidth-1:0] qx;
		logic signed [DataWidth-1:0] qy;
		logic signed [DataWidth-1:0] qz;
	} rmq_out_t;

	// classified item: radicand plus the three numerators in output order
	typedef struct packed {
		rmq_branch_t                 branch;
		logic [RadWidth-1:0]         rad;
		logic signed [DiffWidth-1:0] d0;
		logic signed [DiffWidth-1:0] d1;
		logic signed [DiffWidth-1:0] d2;
	} rmq_work_t;
endpackage

// ===== sv/rmq_front.sv =====
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  rmq_in_t   item,
	output logic      work_valid,
	input  logic      work_ready,
	output rmq_work_t work
);
	logic      v_s1;
	rmq_work_t work_s1;
	rmq_work_t cls;
	logic signed [18:0] e00, e11, e22, tr, rad;
	logic signed [DiffWidth-1:0] a01, a02, a10, a12, a20, a21;

	assign e00 = 19'(item.m00);
	assign e11 = 19'(item.m11);
	assign e22 = 19'(item.m22);
	assign a01 = 17'(item.m01);
	assign a02 = 17'(item.m02);
	assign a10 = 17'(item.m10);
	assign a12 = 17'(item.m12);
	assign a20 = 17'(item.m20);
	assign a21 = 17'(item.m21);
	assign tr  = e00 + e11 + e22;

	always_comb begin
		cls = '0;
		priority if (tr > 19'sd0) begin
			cls.branch = BR_TRACE;
			rad = tr + One;
			cls.d0 = a21 - a12;
			cls.d1 = a02 - a20;
			cls.d2 = a10 - a01;
		end else if (item.m00 > item.m11 && item.m00 > item.m22) begin
			cls.branch = BR_X;
			rad = One + e00 - e11 - e22;
			cls.d0 = a21 - a12;
			cls.d1 = a01 + a10;
			cls.d2 = a02 + a20;
		end else if (item.m11 > item.m22) begin
			cls.branch = BR_Y;
			rad = One + e11 - e00 - e22;
			cls.d0 = a02 - a20;
			cls.d1 = a01 + a10;
			cls.d2 = a12 + a21;
		end else begin
			cls.branch = BR_Z;
			rad = One + e22 - e00 - e11;
			cls.d0 = a10 - a01;
			cls.d1 = a02 + a20;
			cls.d2 = a12 + a21;
		end
		// clamp degenerate radicands to one LSB so S never vanishes
		cls.rad = (rad < 19'sd1) ? RadWidth'(1) : rad[RadWidth-1:0];
	end

	assign full       = v_s1 && !work_ready;
	assign work_valid = v_s1;
	assign work       = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			work_s1 <= cls;
		end
	end
endmodule

// ===== sv/rmq_queue.sv =====
`timescale 1ns / 1ps
module rmq_queue import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  rmq_work_t wr_data,
	output logic      rd_valid,
	input  logic      rd_ready,
	output rmq_work_t rd_data
);
	localparam int PtrW = $clog2(QueueDepth);

	rmq_work_t         mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]     count_q;
	logic              do_wr, do_rd;

	assign wr_ready = count_q != (PtrW+1)'(QueueDepth);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end
endmodule

// ===== sv/rmq_back.sv =====
`timescale 1ns / 1ps
module rmq_back import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      work_valid,
	output logic      work_ready,
	input  rmq_work_t work,
	output logic      empty,
	input  logic      pop,
	output rmq_out_t  result
);
	localparam int Last = SqSteps + 1 + QuoBits;

	logic en;
	logic v_s [0:Last];

	// square-root section
	logic [18:0]         srem_s  [0:SqSteps];
	logic [SqWidth-1:0]  sroot_s [0:SqSteps];
	logic [NumWidth-1:0] sn_s    [0:SqSteps];
	rmq_work_t           sw_s    [0:SqSteps];

	// divider section, three lanes sharing S
	logic [RadWidth-1:0] drem_s [0:QuoBits][3];
	logic [QuoBits-1:0]  dq_s   [0:QuoBits][3];
	logic [NumWidth-1:0] dn_s   [0:QuoBits][3];
	logic                dneg_s [0:QuoBits][3];
	logic [RadWidth-1:0] ds_s   [0:QuoBits];
	logic [SqWidth-1:0]  ddom_s [0:QuoBits];
	rmq_branch_t         dbr_s  [0:QuoBits];

	logic     out_v_q;
	rmq_out_t out_q;

	assign en         = !out_v_q || pop;
	assign work_ready = en;
	assign empty      = !out_v_q;
	assign result     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Last; i++) v_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= work_valid;
			for (int i = 1; i <= Last; i++) v_s[i] <= v_s[i-1];
			out_v_q <= v_s[Last];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srem_s[0]  <= '0;
			sroot_s[0] <= '0;
			sn_s[0]    <= {1'b0, work.rad, FracBits'(0)};
			sw_s[0]    <= work;
		end
	end

	// one root bit per stage, two radicand bits consumed each time
	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		logic [18:0] cand, trial;
		assign cand  = {srem_s[k][16:0], sn_s[k][NumWidth-1-2*k -: 2]};
		assign trial = {1'b0, sroot_s[k], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (cand >= trial) begin
					srem_s[k+1]  <= cand - trial;
					sroot_s[k+1] <= {sroot_s[k][SqWidth-2:0], 1'b1};
				end else begin
					srem_s[k+1]  <= cand;
					sroot_s[k+1] <= {sroot_s[k][SqWidth-2:0], 1'b0};
				end
				sn_s[k+1] <= sn_s[k];
				sw_s[k+1] <= sw_s[k];
			end
		end
	end

	// set up dividends: (|d| << FracBits) + S/2, with S/2 = sq
	logic [SqWidth-1:0] sq;
	logic signed [DiffWidth-1:0] dsel [3];
	assign sq      = sroot_s[SqSteps];
	assign dsel[0] = sw_s[SqSteps].d0;
	assign dsel[1] = sw_s[SqSteps].d1;
	assign dsel[2] = sw_s[SqSteps].d2;

	for (genvar l = 0; l < 3; l++) begin : g_lane_init
		logic [DiffWidth-1:0] mag;
		logic [NumWidth-1:0]  num;
		assign mag = dsel[l][DiffWidth-1] ? DiffWidth'(-dsel[l]) : DiffWidth'(dsel[l]);
		assign num = {1'b0, mag, FracBits'(0)} + NumWidth'(sq);
		always_ff @(posedge clk) begin
			if (en) begin
				dn_s[0][l]   <= num;
				drem_s[0][l] <= RadWidth'(num[NumWidth-1:QuoBits]);
				dq_s[0][l]   <= '0;
				dneg_s[0][l] <= dsel[l][DiffWidth-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s[0]   <= {sq, 1'b0};
			ddom_s[0] <= SqWidth'((17'(sq) + 17'd1) >> 1);
			dbr_s[0]  <= sw_s[SqSteps].branch;
		end
	end

	for (genvar j = 0; j < QuoBits; j++) begin : g_div
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [RadWidth:0] cand;
			logic              ge;
			assign cand = {drem_s[j][l], dn_s[j][l][QuoBits-1-j]};
			assign ge   = cand >= {1'b0, ds_s[j]};
			always_ff @(posedge clk) begin
				if (en) begin
					drem_s[j+1][l] <= ge ? RadWidth'(cand - {1'b0, ds_s[j]})
					                     : RadWidth'(cand);
					dq_s[j+1][l]   <= {dq_s[j][l][QuoBits-2:0], ge};
					dn_s[j+1][l]   <= dn_s[j][l];
					dneg_s[j+1][l] <= dneg_s[j][l];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ds_s[j+1]   <= ds_s[j];
				ddom_s[j+1] <= ddom_s[j];
				dbr_s[j+1]  <= dbr_s[j];
			end
		end
	end

	// apply sign, saturate, place the dominant term
	logic [DataWidth-1:0] qv [3];
	for (genvar l = 0; l < 3; l++) begin : g_sat
		logic [QuoBits-1:0] q;
		assign q = dq_s[QuoBits][l];
		always_comb begin
			if (dneg_s[QuoBits][l]) begin
				qv[l] = (q > QuoBits'(32768)) ? 16'h8000 : 16'(-q[DataWidth-1:0]);
			end else begin
				qv[l] = (q > QuoBits'(32767)) ? 16'h7fff : q[DataWidth-1:0];
			end
		end
	end

	rmq_out_t mapped;
	logic [DataWidth-1:0] dom;
	assign dom = ddom_s[QuoBits];

	always_comb begin
		unique case (dbr_s[QuoBits])
			BR_TRACE: mapped = {dom, qv[0], qv[1], qv[2]};
			BR_X:     mapped = {qv[0], dom, qv[1], qv[2]};
			BR_Y:     mapped = {qv[0], qv[1], dom, qv[2]};
			BR_Z:     mapped = {qv[0], qv[1], qv[2], dom};
			default:  mapped = {qv[0], qv[1], qv[2], dom};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= mapped;
	end
endmodule

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion, signed Q2.14 in and out.
// Input channel: present a 3x3 matrix on item with push; it is taken on a
// clock edge where push is high and full is low. Result channel: while empty
// is low the oldest quaternion sits on result; pop takes it.
// One matrix per cycle sustained while the receiver does not hold off pop. An
// accepted beat passes through an input register that classifies the branch,
// a 4-entry queue, a load stage, a 16-stage square root that retires one root
// bit per stage, a dividend setup stage, a 23-stage three-lane divider retiring
// one quotient bit per stage, and the output register.
// Reset (arst_n low) empties the queue and the pipeline; empty goes high.
// When the receiver holds off pop, the back pipeline freezes with the result
// held; the queue keeps taking beats until it fills, then full rises.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  rmq_in_t  item,
	output logic     empty,
	input  logic     pop,
	output rmq_out_t result
);
	logic      fw_valid, fw_ready, bk_valid, bk_ready;
	rmq_work_t fw_data, bk_data;

	rmq_front u_front (
		.clk, .arst_n, .push, .full, .item,
		.work_valid(fw_valid), .work_ready(fw_ready), .work(fw_data)
	);

	rmq_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fw_valid), .wr_ready(fw_ready), .wr_data(fw_data),
		.rd_valid(bk_valid), .rd_ready(bk_ready), .rd_data(bk_data)
	);

	rmq_back u_back (
		.clk, .arst_n,
		.work_valid(bk_valid), .work_ready(bk_ready), .work(bk_data),
		.empty, .pop, .result
	);
endmodule

// ===== sv/rmq_checker.sv =====
`timescale 1ns / 1ps
module rmq_checker import rmq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     full,
	input logic     empty,
	input logic     pop,
	input rmq_out_t result
);
	// nothing waits and nothing blocks right after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("result shown or input blocked right after reset");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

	// dominant term is S/4 and positive, so at least one component is nonnegative
	a_dom_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!result.qw[DataWidth-1] || !result.qx[DataWidth-1] ||
		            !result.qy[DataWidth-1] || !result.qz[DataWidth-1]))
		else $error("no nonnegative component in result");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
	.clk, .arst_n, .full, .empty, .pop, .result
);
